FILE: rtl/pi_voltage_loop_pwm_compare_defines.svh
// Assertion macros used by the voltage loop PI core.
`ifndef PI_VOLTAGE_LOOP_PWM_COMPARE_DEFINES_SVH
`define PI_VOLTAGE_LOOP_PWM_COMPARE_DEFINES_SVH

`ifndef SYNTHESIS
`define PVL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pvl assertion failed");
`define PVL_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pvl forbidden condition seen");
`else
`define PVL_ASSERT(label, clk, rst, prop)
`define PVL_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: rtl/pvl_pkg.sv
`timescale 1ns / 1ps

package pvl_pkg;

  localparam int AdcW     = 12;
  localparam int GainW    = 24;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 3;
  localparam int ErrW     = 13;
  localparam int IntegW   = 40;
  localparam int TotalW   = 29;
  localparam int FracW    = 16;

  localparam int WindowDefault = 256;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_TRIP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_CLAMP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PWM_PERIOD  = 3'd6;

  localparam logic [AdcW-1:0]  SetpointReset   = 12'd3030;
  localparam logic [GainW-1:0] PropGainReset   = 24'd167772;
  localparam logic [GainW-1:0] IntegGainReset  = 24'd6711;
  localparam logic [AdcW-1:0]  IntegLimitReset = 12'd1250;
  localparam logic [AdcW-1:0]  OutTripReset    = 12'd1400;
  localparam logic [AdcW-1:0]  OutClampReset   = 12'd1350;
  localparam logic [AdcW-1:0]  PwmPeriodReset  = 12'd1500;

  typedef struct packed {
    logic [AdcW-1:0] adc_sample;
    logic            sample_enable;
    logic            output_enable;
  } in_item_t;

  typedef struct packed {
    logic [AdcW-1:0] compare_value;
    logic            drive_on;
    logic            loop_updated;
  } out_item_t;

  typedef struct packed {
    logic [AdcW-1:0]  setpoint;
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [AdcW-1:0]  integ_limit;
    logic [AdcW-1:0]  out_trip;
    logic [AdcW-1:0]  out_clamp;
    logic [AdcW-1:0]  pwm_period;
  } cfg_t;

endpackage

FILE: rtl/pvl_cfg_regs.sv
`timescale 1ns / 1ps

module pvl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pvl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pvl_pkg::CfgDataW-1:0]  cfg_data,
  output pvl_pkg::cfg_t                 cfg
);
  import pvl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint    <= SetpointReset;
      cfg.prop_gain   <= PropGainReset;
      cfg.integ_gain  <= IntegGainReset;
      cfg.integ_limit <= IntegLimitReset;
      cfg.out_trip    <= OutTripReset;
      cfg.out_clamp   <= OutClampReset;
      cfg.pwm_period  <= PwmPeriodReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT:    cfg.setpoint    <= cfg_data[AdcW-1:0];
        REG_PROP_GAIN:   cfg.prop_gain   <= cfg_data[GainW-1:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data[GainW-1:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= cfg_data[AdcW-1:0];
        REG_OUT_TRIP:    cfg.out_trip    <= cfg_data[AdcW-1:0];
        REG_OUT_CLAMP:   cfg.out_clamp   <= cfg_data[AdcW-1:0];
        REG_PWM_PERIOD:  cfg.pwm_period  <= cfg_data[AdcW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pvl_pi_core.sv
`timescale 1ns / 1ps
`include "pi_voltage_loop_pwm_compare_defines.svh"

module pvl_pi_core #(
  parameter int WINDOW = pvl_pkg::WindowDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  pvl_pkg::in_item_t  item,
  input  pvl_pkg::cfg_t      cfg,
  output pvl_pkg::out_item_t result
);
  import pvl_pkg::*;

  localparam int CntW = $clog2(WINDOW + 1);
  localparam logic [CntW-1:0] WindowCount = CntW'(WINDOW);

  logic signed [ErrW-1:0]   previous_error;
  logic signed [IntegW-1:0] integrator;
  logic [TotalW-1:0]        held_total;
  logic [CntW-1:0]          sample_counter;

  logic signed [ErrW-1:0]     err;
  logic signed [ErrW:0]       esum;
  logic signed [38:0]         iprod;
  logic signed [30:0]         ishift;
  logic signed [IntegW:0]     isum;
  logic signed [IntegW:0]     lim_ext;
  logic signed [IntegW-1:0]   integrator_next;
  logic [27:0]                integ_used;
  logic signed [37:0]         pprod;
  logic signed [29:0]         pshift;
  logic signed [30:0]         total;
  logic signed [30:0]         trip_ext;
  logic [TotalW-1:0]          held_total_next;
  logic [TotalW-1:0]          held_used;
  logic                       do_update;
  logic signed [13:0]         cmp_diff;

  assign do_update = item.sample_enable && (sample_counter < WindowCount);

  assign err  = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, item.adc_sample});
  assign esum = {err[ErrW-1], err} + {previous_error[ErrW-1], previous_error};

  // Products are exact in Q.24; dropping 8 bits floors them to Q.16.
  assign iprod  = esum * $signed({1'b0, cfg.integ_gain});
  assign ishift = iprod[38:8];
  assign isum   = {{10{ishift[30]}}, ishift} + {integrator[IntegW-1], integrator};
  assign lim_ext = $signed({13'b0, cfg.integ_limit, 16'b0});

  always_comb begin
    if (isum >= lim_ext) begin
      integrator_next = lim_ext[IntegW-1:0];
    end else if (isum[IntegW:IntegW-1] == 2'b10) begin
      // Below the most negative value of the stored integrator.
      integrator_next = {1'b1, {(IntegW-1){1'b0}}};
    end else begin
      integrator_next = isum[IntegW-1:0];
    end
  end

  assign integ_used = integrator_next[IntegW-1] ? 28'd0 : integrator_next[27:0];

  assign pprod    = err * $signed({1'b0, cfg.prop_gain});
  assign pshift   = pprod[37:8];
  assign total    = {pshift[29], pshift} + $signed({3'b0, integ_used});
  assign trip_ext = $signed({3'b0, cfg.out_trip, 16'b0});

  always_comb begin
    if (total >= trip_ext) begin
      held_total_next = {1'b0, cfg.out_clamp, 16'b0};
    end else if (total[30]) begin
      held_total_next = '0;
    end else begin
      held_total_next = total[TotalW-1:0];
    end
  end

  assign held_used = do_update ? held_total_next : held_total;
  assign cmp_diff  = $signed({2'b0, cfg.pwm_period}) - $signed({1'b0, held_used[28:16]});

  always_comb begin
    result.drive_on      = item.output_enable;
    result.loop_updated  = do_update;
    result.compare_value = '0;
    if (item.output_enable && !cmp_diff[13]) begin
      result.compare_value = cmp_diff[AdcW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integrator     <= '0;
      held_total     <= '0;
      sample_counter <= '0;
    end else if (fire && item.sample_enable) begin
      if (do_update) begin
        previous_error <= err;
        integrator     <= integrator_next;
        held_total     <= held_total_next;
        sample_counter <= sample_counter + 1'b1;
      end else begin
        sample_counter <= '0;
      end
    end
  end

  `PVL_ASSERT(a_integ_limit, clk, rst, fire && do_update |=> integrator <= $past(lim_ext))
  `PVL_NEVER(a_held_range, clk, rst, held_total[TotalW-1])
  `PVL_NEVER(a_count_range, clk, rst, sample_counter > WindowCount)
  `PVL_ASSERT(a_window_skip, clk, rst, fire && item.sample_enable && !do_update |=> sample_counter == '0)

endmodule

FILE: rtl/pi_voltage_loop_pwm_compare.sv
`timescale 1ns / 1ps
// A result is offered once its item has passed the input register and then
// the PI update into the result register; both hold while out_stall blocks.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// Reset (rst, synchronous, active high) loads the register defaults and clears
// the loop state, the sample counter and both pipeline stages.
module pi_voltage_loop_pwm_compare #(
  parameter int WINDOW = pvl_pkg::WindowDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pvl_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pvl_pkg::out_item_t            out_data,
  input  logic                          cfg_write,
  input  logic [pvl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pvl_pkg::CfgDataW-1:0]  cfg_data
);
  import pvl_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      advance;
  logic      fire;
  out_item_t result;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  pvl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pvl_pi_core #(
    .WINDOW (WINDOW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

endmodule
